/* sv/ifd_pkg.sv */
// Shared types, constants and field layout helpers for the frame deframer.
// No dependencies; every other file of the block imports this package.
package ifd_pkg;

  // Frame framing constants.
  localparam logic [7:0] PRE1_BYTE = 8'hFB;
  localparam logic [7:0] PRE2_BYTE = 8'hFC;
  localparam logic [7:0] END1_BYTE = 8'hA1;
  localparam logic [7:0] END2_BYTE = 8'hA2;

  localparam int PAYLOAD_LEN = 63;
  localparam int ADDR_W      = 6;
  localparam int FIELD_COUNT = 29;
  localparam int FIDX_W      = 5;

  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(PAYLOAD_LEN - 1);
  localparam logic [FIDX_W-1:0] LAST_FIELD = FIDX_W'(FIELD_COUNT - 1);

  // Parser and emission sequencer states.
  typedef enum logic [3:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_DATA,
    PH_SUM,
    PH_END1,
    PH_END2,
    PH_EMIT_RD,
    PH_EMIT_ACC,
    PH_EMIT_OUT
  } phase_t;

  // Kind of a decoded field.
  typedef enum logic [1:0] {
    FK_BYTE,
    FK_S16,
    FK_U32
  } fkind_t;

  // Control from the sequencer to the field assembler.
  typedef struct packed {
    logic              shift;
    logic              load;
    fkind_t            kind;
    logic [FIDX_W-1:0] index;
    logic              last;
  } asm_ctrl_t;

  // Field kind by position in the frame layout.
  function automatic fkind_t field_kind(input logic [FIDX_W-1:0] idx);
    fkind_t k;
    k = FK_BYTE;
    if (idx inside {5'd1, [5'd14:5'd16]}) begin
      k = FK_U32;
    end else if (idx inside {[5'd2:5'd13], [5'd17:5'd26]}) begin
      k = FK_S16;
    end
    return k;
  endfunction

  // Number of payload bytes in a field.
  function automatic logic [2:0] field_len(input logic [FIDX_W-1:0] idx);
    logic [2:0] n;
    case (field_kind(idx))
      FK_U32:  n = 3'd4;
      FK_S16:  n = 3'd2;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

/* sv/ifd_payload_ram.sv */
// Payload store of the frame deframer: 63 bytes, one write and one read port.
// Depends on ifd_pkg for the depth and address width.
module ifd_payload_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ifd_pkg::ADDR_W-1:0] waddr,
  input  logic [7:0]                 wdata,
  input  logic [ifd_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                 rdata
);
  import ifd_pkg::*;

  logic [7:0] mem [PAYLOAD_LEN];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/ifd_field_asm.sv */
// Field assembler: shifts payload bytes into an accumulator, then formats
// and holds one output beat. Depends on ifd_pkg for the control struct.
module ifd_field_asm (
  input  logic                       clk,
  input  logic                       rst,
  input  ifd_pkg::asm_ctrl_t         ctrl,
  input  logic [7:0]                 rd_byte,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [ifd_pkg::FIDX_W-1:0] field_index,
  output logic signed [31:0]         field_value,
  output logic                       last_field
);
  import ifd_pkg::*;

  logic [31:0] acc;
  logic [31:0] acc_next;
  logic [31:0] fmt;

  // Big-endian accumulation of one byte per step.
  assign acc_next = {acc[23:0], rd_byte};

  // Width selection and sign extension of the finished field.
  always_comb begin
    case (ctrl.kind)
      FK_U32:  fmt = acc_next;
      FK_S16:  fmt = {{16{acc_next[15]}}, acc_next[15:0]};
      default: fmt = {24'd0, acc_next[7:0]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      acc <= acc_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      field_index <= ctrl.index;
      field_value <= fmt;
      last_field  <= ctrl.last;
    end
  end

endmodule

/* sv/ins_frame_deframer_unit.sv */
// Frame deframer top level: byte parser, payload store and field emission.
// out_valid for a frame's first field rises once its 0xA2 beat is accepted and the
// sequencer has passed PH_EMIT_RD and PH_EMIT_ACC. Throughput: one input beat per cycle
// while parsing; after a valid frame the input stalls for the 63 store reads through the
// shared assembler and for one output beat per field, 29 in all.
// Reset: synchronous, returns the parser to the preamble hunt; no store clearing.
module ins_frame_deframer_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ifd_pkg::FIDX_W-1:0] field_index,
  output logic signed [31:0]         field_value,
  output logic                       last_field
);
  import ifd_pkg::*;

  phase_t            state;
  phase_t            state_next;
  logic [ADDR_W-1:0] count;
  logic [7:0]        sum;
  logic [FIDX_W-1:0] fidx;
  logic [2:0]        bleft;
  logic [ADDR_W-1:0] raddr;

  logic              in_fire;
  logic              out_fire;
  logic              mem_we;
  logic [7:0]        rd_byte;
  asm_ctrl_t         ctrl;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      PH_HUNT1: begin
        if (in_fire) state_next = (rx_byte == PRE1_BYTE) ? PH_HUNT2 : PH_HUNT1;
      end
      PH_HUNT2: begin
        if (in_fire) state_next = (rx_byte == PRE2_BYTE) ? PH_DATA : PH_HUNT1;
      end
      PH_DATA: begin
        if (in_fire && count == LAST_ADDR) state_next = PH_SUM;
      end
      PH_SUM: begin
        if (in_fire) state_next = (rx_byte == sum) ? PH_END1 : PH_HUNT1;
      end
      PH_END1: begin
        if (in_fire) state_next = (rx_byte == END1_BYTE) ? PH_END2 : PH_HUNT1;
      end
      PH_END2: begin
        if (in_fire) state_next = (rx_byte == END2_BYTE) ? PH_EMIT_RD : PH_HUNT1;
      end
      PH_EMIT_RD: begin
        state_next = PH_EMIT_ACC;
      end
      PH_EMIT_ACC: begin
        state_next = (bleft == 3'd1) ? PH_EMIT_OUT : PH_EMIT_RD;
      end
      PH_EMIT_OUT: begin
        if (out_fire) state_next = (fidx == LAST_FIELD) ? PH_HUNT1 : PH_EMIT_RD;
      end
      default: begin
        state_next = PH_HUNT1;
      end
    endcase
  end

  // Output and control logic.
  always_comb begin
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    ctrl.shift = 1'b0;
    ctrl.load  = 1'b0;
    ctrl.kind  = field_kind(fidx);
    ctrl.index = fidx;
    ctrl.last  = (fidx == LAST_FIELD);
    case (state)
      PH_HUNT1, PH_HUNT2, PH_SUM, PH_END1, PH_END2: begin
        in_ready = 1'b1;
      end
      PH_DATA: begin
        in_ready = 1'b1;
        mem_we   = in_fire;
      end
      PH_EMIT_ACC: begin
        ctrl.shift = 1'b1;
        ctrl.load  = (bleft == 3'd1);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PH_HUNT1;
    end else begin
      state <= state_next;
    end
  end

  // Payload counter and running checksum.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
    end else if (in_fire) begin
      case (state)
        PH_HUNT2: begin
          if (rx_byte == PRE2_BYTE) begin
            count <= '0;
            sum   <= '0;
          end
        end
        PH_DATA: begin
          sum   <= sum + rx_byte;
          count <= (count == LAST_ADDR) ? '0 : count + 1'b1;
        end
        PH_SUM: begin
          if (rx_byte != sum) sum <= '0;
        end
        PH_END1: begin
          if (rx_byte != END1_BYTE) sum <= '0;
        end
        PH_END2: begin
          if (rx_byte != END2_BYTE) sum <= '0;
        end
        default: begin
          sum <= sum;
        end
      endcase
    end
  end

  // Emission sequencer: field index, bytes left in the field, read address.
  always_ff @(posedge clk) begin
    if (rst) begin
      fidx  <= '0;
      bleft <= '0;
      raddr <= '0;
    end else if (state == PH_END2 && in_fire && rx_byte == END2_BYTE) begin
      fidx  <= '0;
      bleft <= field_len('0);
      raddr <= '0;
    end else if (state == PH_EMIT_ACC) begin
      bleft <= bleft - 3'd1;
      raddr <= (raddr == LAST_ADDR) ? '0 : raddr + 1'b1;
    end else if (state == PH_EMIT_OUT && out_fire && fidx != LAST_FIELD) begin
      fidx  <= fidx + 1'b1;
      bleft <= field_len(fidx + 1'b1);
    end
  end

  ifd_payload_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count),
    .wdata (rx_byte),
    .raddr (raddr),
    .rdata (rd_byte)
  );

  ifd_field_asm u_asm (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .rd_byte     (rd_byte),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .field_index (field_index),
    .field_value (field_value),
    .last_field  (last_field)
  );

endmodule

/* tb/tb_ins_frame_deframer_unit.sv */
// Self-checking testbench for ins_frame_deframer_unit: byte stream in, decoded fields out.
// Depends on ifd_pkg for the framing bytes, layout sizes and parser state names.
`timescale 1ns / 1ps

module tb_ins_frame_deframer_unit;
  import ifd_pkg::*;

  // Decoded field as it leaves the block.
  typedef struct {
    logic [FIDX_W-1:0] index;
    logic [31:0]       value;
    logic              last;
  } field_rec_t;

  // Ways a generated frame can be spoiled.
  typedef enum {
    FLAW_NONE,
    FLAW_SUM,
    FLAW_END1,
    FLAW_END2,
    FLAW_PRE2
  } frame_flaw_t;

  // Payload content patterns.
  typedef enum {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES,
    FILL_SIGN,
    FILL_MAXPOS,
    FILL_MARKERS
  } fill_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [FIDX_W-1:0]     field_index;
  logic signed [31:0]    field_value;
  logic                  last_field;

  // Stimulus and expectation stores.
  logic [7:0]  tx_bytes[$];
  field_rec_t  pending_fields[$];

  // Shadow copy of the parser.
  phase_t      frame_phase = PH_HUNT1;
  int          stored_count = 0;
  logic [7:0]  payload_sum = 8'h00;
  logic [7:0]  payload_copy[PAYLOAD_LEN];

  // Handshake bookkeeping.
  logic        in_beat = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  // Counters.
  int          bytes_total = 0;
  int          bytes_taken = 0;
  int          fields_seen = 0;
  int          frames_decoded = 0;
  int          mismatches = 0;

  ins_frame_deframer_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .field_index (field_index),
    .field_value (field_value),
    .last_field  (last_field)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Random idle length: mostly short, now and then long, none in a calm stretch.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Queue the 29 fields of the stored payload, walking the layout byte by byte.
  task automatic queue_decoded_fields();
    int         pos;
    int         len;
    field_rec_t rec;
    pos = 0;
    for (int idx = 0; idx < FIELD_COUNT; idx++) begin
      if (idx == 1 || (idx >= 14 && idx <= 16)) begin
        len = 4;
      end else if ((idx >= 2 && idx <= 13) || (idx >= 17 && idx <= 26)) begin
        len = 2;
      end else begin
        len = 1;
      end
      rec.value = 32'd0;
      for (int k = 0; k < len; k++) begin
        rec.value = {rec.value[23:0], payload_copy[pos + k]};
      end
      // Halfwords carry a sign; single bytes do not.
      if (len == 2 && rec.value[15]) begin
        rec.value[31:16] = 16'hFFFF;
      end
      rec.index = FIDX_W'(idx);
      rec.last  = (idx == FIELD_COUNT - 1);
      pending_fields.push_back(rec);
      pos += len;
    end
    frames_decoded++;
  endtask

  // Advance the shadow parser by one received byte.
  task automatic parse_rx_byte(input logic [7:0] b);
    case (frame_phase)
      PH_HUNT2: begin
        // A wrong second preamble byte is dropped, not retried as a first one.
        if (b == PRE2_BYTE) begin
          frame_phase  = PH_DATA;
          payload_sum  = 8'h00;
          stored_count = 0;
        end else begin
          frame_phase = PH_HUNT1;
        end
      end
      PH_DATA: begin
        payload_copy[stored_count] = b;
        payload_sum  = payload_sum + b;
        stored_count = stored_count + 1;
        if (stored_count == PAYLOAD_LEN) begin
          stored_count = 0;
          frame_phase  = PH_SUM;
        end
      end
      PH_SUM: begin
        if (b == payload_sum) begin
          frame_phase = PH_END1;
        end else begin
          frame_phase = PH_HUNT1;
          payload_sum = 8'h00;
        end
      end
      PH_END1: begin
        if (b == END1_BYTE) begin
          frame_phase = PH_END2;
        end else begin
          frame_phase = PH_HUNT1;
          payload_sum = 8'h00;
        end
      end
      PH_END2: begin
        frame_phase = PH_HUNT1;
        if (b == END2_BYTE) begin
          queue_decoded_fields();
        end else begin
          payload_sum = 8'h00;
        end
      end
      default: begin
        frame_phase = (b == PRE1_BYTE) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  endtask

  // Random byte leaning toward the framing markers and the value extremes.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    case (r % 10)
      0: return (r < 50) ? 8'h00 : 8'hFF;
      1: return (r < 50) ? 8'h80 : 8'h7F;
      2: begin
        case (r % 4)
          0: return PRE1_BYTE;
          1: return PRE2_BYTE;
          2: return END1_BYTE;
          default: return END2_BYTE;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Queue one frame, possibly spoiled at one point.
  task automatic add_frame(input frame_flaw_t flaw, input fill_t fill);
    logic [7:0] pay[PAYLOAD_LEN];
    logic [7:0] sum;
    logic [7:0] bad;
    sum = 8'h00;
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      case (fill)
        FILL_ZERO:    pay[i] = 8'h00;
        FILL_ONES:    pay[i] = 8'hFF;
        FILL_SIGN:    pay[i] = i[0] ? 8'h00 : 8'h80;
        FILL_MAXPOS:  pay[i] = i[0] ? 8'hFF : 8'h7F;
        FILL_MARKERS: begin
          case (i % 4)
            0: pay[i] = PRE1_BYTE;
            1: pay[i] = PRE2_BYTE;
            2: pay[i] = END1_BYTE;
            default: pay[i] = END2_BYTE;
          endcase
        end
        default:      pay[i] = pick_byte();
      endcase
      sum = sum + pay[i];
    end

    tx_bytes.push_back(PRE1_BYTE);
    if (flaw == FLAW_PRE2) begin
      bad = $urandom_range(0, 1) ? PRE1_BYTE : 8'($urandom_range(0, 255));
      if (bad == PRE2_BYTE) begin
        bad = 8'h00;
      end
      tx_bytes.push_back(bad);
      return;
    end
    tx_bytes.push_back(PRE2_BYTE);
    foreach (pay[i]) begin
      tx_bytes.push_back(pay[i]);
    end

    // The spoiling byte is sometimes a first preamble byte, which must be consumed.
    if (flaw == FLAW_SUM) begin
      bad = sum + 8'($urandom_range(1, 255));
      if ($urandom_range(0, 1) && sum != PRE1_BYTE) begin
        bad = PRE1_BYTE;
      end
      tx_bytes.push_back(bad);
      return;
    end
    tx_bytes.push_back(sum);

    if (flaw == FLAW_END1) begin
      bad = $urandom_range(0, 1) ? PRE1_BYTE : 8'($urandom_range(0, 255));
      if (bad == END1_BYTE) begin
        bad = END2_BYTE;
      end
      tx_bytes.push_back(bad);
      return;
    end
    tx_bytes.push_back(END1_BYTE);

    if (flaw == FLAW_END2) begin
      bad = $urandom_range(0, 1) ? PRE1_BYTE : 8'($urandom_range(0, 255));
      if (bad == END2_BYTE) begin
        bad = END1_BYTE;
      end
      tx_bytes.push_back(bad);
      return;
    end
    tx_bytes.push_back(END2_BYTE);
  endtask

  // Input driver: one byte per beat, random gaps between beats.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap = in_gap - 1;
      end else if (tx_bytes.size() > 0) begin
        in_valid <= 1'b1;
        rx_byte  <= tx_bytes.pop_front();
        in_gap = pick_gap(in_calm);
        if ($urandom_range(0, 63) == 0) begin
          in_calm = !in_calm;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output backpressure with random stalls.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall = out_stall - 1;
    end else begin
      out_ready <= 1'b1;
      out_stall = pick_gap(out_calm);
      if ($urandom_range(0, 63) == 0) begin
        out_calm = !out_calm;
      end
    end
  end

  // Monitor: feed accepted bytes to the shadow parser, then check output beats.
  always @(posedge clk) begin
    field_rec_t want;
    in_beat <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      parse_rx_byte(rx_byte);
      bytes_taken++;
    end
    if (!rst && out_valid && out_ready) begin
      fields_seen++;
      if (pending_fields.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] unexpected field: index %0d value %08h last %b", $realtime,
                   field_index, field_value, last_field);
        end
      end else begin
        want = pending_fields.pop_front();
        if (field_index !== want.index || field_value !== want.value ||
            last_field !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] field mismatch: expected index %0d value %08h last %b,",
                     $realtime, want.index, want.value, want.last);
            $display("    got index %0d value %08h last %b",
                     field_index, field_value, last_field);
          end
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int directed_len;
    int r;
    int waited;

    // Wrong second preamble: the repeated 0xFB must not count as a fresh start.
    tx_bytes.push_back(PRE1_BYTE);
    tx_bytes.push_back(PRE1_BYTE);
    tx_bytes.push_back(PRE2_BYTE);
    tx_bytes.push_back(8'h00);
    // A short rejected start, then a good frame of value extremes.
    add_frame(FLAW_PRE2, FILL_RANDOM);
    add_frame(FLAW_NONE, $urandom_range(0, 1) ? FILL_SIGN : FILL_MAXPOS);
    directed_len = tx_bytes.size();

    // A second frame right behind it, either good or rejected at one point.
    r = $urandom_range(0, 3);
    case (r)
      0: add_frame(FLAW_SUM, FILL_MARKERS);
      1: add_frame(FLAW_END1, FILL_RANDOM);
      2: add_frame(FLAW_END2, FILL_RANDOM);
      default: add_frame(FLAW_NONE, FILL_MARKERS);
    endcase

    // Line noise to round out the stream.
    while (tx_bytes.size() < 160) begin
      tx_bytes.push_back(pick_byte());
    end
    bytes_total = tx_bytes.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (bytes_taken < bytes_total) @(posedge clk);
    waited = 0;
    while (pending_fields.size() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    // Leave room for any stray beat after the last expected field.
    repeat (200) @(posedge clk);
    if (pending_fields.size() > 0) begin
      $display("%0d expected fields never arrived", pending_fields.size());
      mismatches += pending_fields.size();
    end

    $display("Sent %0d bytes (%0d directed); %0d frames decoded, %0d fields checked.",
             bytes_total, directed_len, frames_decoded, fields_seen);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4000000;
    $display("Timeout with %0d of %0d bytes taken", bytes_taken, bytes_total);
    $display("Some tests failed");
    $finish;
  end

endmodule

/* filelist.f */
sv/ifd_pkg.sv
sv/ifd_payload_ram.sv
sv/ifd_field_asm.sv
sv/ins_frame_deframer_unit.sv
tb/tb_ins_frame_deframer_unit.sv
